>>> rtl/cseg_pkg.sv
// ----------------------------------------------------------------------------
// cseg_pkg: shared types and constants of the CSR element gather block
// Request and result payloads, action codes, register indexes, controller
// states and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package cseg_pkg;

  localparam int unsigned SLOT_W     = 8;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned HALF_W     = 32;
  localparam int unsigned ELEM_W     = 16;
  localparam int unsigned DENSE_W    = ELEM_W + 1;
  localparam int unsigned PTR_W      = 9;
  localparam int unsigned COL_W      = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned DIV_CNT_W  = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS_PER_ROW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_SKIP     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_PRECISION = 2'd2;

  typedef enum logic [1:0] {
    ACT_LOAD_ROW_END = 2'd0,
    ACT_LOAD_COLUMN  = 2'd1,
    ACT_LOAD_VALUE   = 2'd2,
    ACT_FETCH        = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_PTR_START,
    ST_PTR_END,
    ST_PTR_CAP,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_DONE
  } state_e;

  typedef struct packed {
    action_e             action;
    logic [SLOT_W-1:0]   slot;
    logic [WORD_W-1:0]   load_word;
    logic [ELEM_W-1:0]   element;
    logic                last_in;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic              found;
    logic              out_of_range;
    logic              last_out;
  } out_item_t;

  typedef struct packed {
    logic fetch_start;
    logic load_write;
    logic div_step;
    logic ptr_sel_end;
    logic cap_start;
    logic cap_end;
    logic pos_inc;
    logic cap_hit;
    logic result_load;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic row_oor;
    logic scan_end;
    logic col_match;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/cseg_ram.sv
// ----------------------------------------------------------------------------
// cseg_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module cseg_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/cseg_ctrl.sv
// ----------------------------------------------------------------------------
// cseg_ctrl: sequencer of the CSR element gather block
// Accepts requests, steps the divider, the pointer reads and the row scan,
// and hands the finished result to the output register.
// ----------------------------------------------------------------------------
module cseg_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  cseg_pkg::action_e in_action_i,
  output logic             in_ready_o,
  input  cseg_pkg::sts_t   sts_i,
  output cseg_pkg::cmd_t   cmd_o
);

  cseg_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cseg_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cseg_pkg::ST_IDLE: begin
        if (in_valid_i && (in_action_i == cseg_pkg::ACT_FETCH)) begin
          state_d = cseg_pkg::ST_DIVIDE;
        end
      end
      cseg_pkg::ST_DIVIDE: begin
        if (sts_i.div_last) begin
          state_d = cseg_pkg::ST_PTR_START;
        end
      end
      cseg_pkg::ST_PTR_START: begin
        state_d = sts_i.row_oor ? cseg_pkg::ST_DONE : cseg_pkg::ST_PTR_END;
      end
      cseg_pkg::ST_PTR_END:   state_d = cseg_pkg::ST_PTR_CAP;
      cseg_pkg::ST_PTR_CAP:   state_d = cseg_pkg::ST_SCAN_RD;
      cseg_pkg::ST_SCAN_RD: begin
        state_d = sts_i.scan_end ? cseg_pkg::ST_DONE : cseg_pkg::ST_SCAN_CHK;
      end
      cseg_pkg::ST_SCAN_CHK: begin
        state_d = sts_i.col_match ? cseg_pkg::ST_DONE : cseg_pkg::ST_SCAN_RD;
      end
      cseg_pkg::ST_DONE: begin
        if (sts_i.out_free) begin
          state_d = cseg_pkg::ST_IDLE;
        end
      end
      default: state_d = cseg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      cseg_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.fetch_start = (in_action_i == cseg_pkg::ACT_FETCH);
          cmd_o.load_write  = (in_action_i != cseg_pkg::ACT_FETCH);
        end
      end
      cseg_pkg::ST_DIVIDE:    cmd_o.div_step = 1'b1;
      cseg_pkg::ST_PTR_START: cmd_o.ptr_sel_end = 1'b0;
      cseg_pkg::ST_PTR_END: begin
        cmd_o.cap_start   = 1'b1;
        cmd_o.ptr_sel_end = 1'b1;
      end
      cseg_pkg::ST_PTR_CAP:   cmd_o.cap_end = 1'b1;
      cseg_pkg::ST_SCAN_RD:   cmd_o.pos_inc = 1'b0;
      cseg_pkg::ST_SCAN_CHK: begin
        cmd_o.cap_hit = sts_i.col_match;
        cmd_o.pos_inc = !sts_i.col_match;
      end
      cseg_pkg::ST_DONE:      cmd_o.result_load = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

>>> rtl/cseg_dp.sv
// ----------------------------------------------------------------------------
// cseg_dp: datapath of the CSR element gather block
// Configuration registers, the three stores, a restoring divider, the row
// pointer and scan registers, and the output register.
// ----------------------------------------------------------------------------
module cseg_dp #(
  parameter int unsigned MAX_ROWS    = 64,
  parameter int unsigned MAX_NONZERO = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [cseg_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [cseg_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  cseg_pkg::in_item_t                  in_data_i,
  input  cseg_pkg::cmd_t                      cmd_i,
  output cseg_pkg::sts_t                      sts_o,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output cseg_pkg::out_item_t                 out_data_o
);

  localparam int unsigned RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned NW = (MAX_NONZERO > 1) ? $clog2(MAX_NONZERO) : 1;

  // configuration
  logic [cseg_pkg::CFG_DATA_W-1:0] cols_q, skip_q;
  logic                            dp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= cseg_pkg::CFG_DATA_W'(1);
      skip_q <= '0;
      dp_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        cseg_pkg::CFG_COLUMNS_PER_ROW:  cols_q <= cfg_data_i;
        cseg_pkg::CFG_ELEMENT_SKIP:     skip_q <= cfg_data_i;
        cseg_pkg::CFG_DOUBLE_PRECISION: dp_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // stores
  logic                        row_ok, nz_ok;
  logic                        row_we, col_we, val_we;
  logic [RW-1:0]               row_raddr;
  logic [cseg_pkg::PTR_W-1:0]  row_rdata;
  logic [cseg_pkg::COL_W-1:0]  col_rdata;
  logic [cseg_pkg::WORD_W-1:0] val_rdata;

  logic [cseg_pkg::DENSE_W-1:0] quot_q, quot_d;
  logic [cseg_pkg::COL_W-1:0]   rem_q, rem_d;
  logic [cseg_pkg::DIV_CNT_W-1:0] div_cnt_q;
  logic [cseg_pkg::PTR_W-1:0]   start_q, end_q, pos_q;
  logic                         hit_q, last_q;
  logic [cseg_pkg::WORD_W-1:0]  value_q;

  assign row_ok = 32'(in_data_i.slot) < MAX_ROWS;
  assign nz_ok  = 32'(in_data_i.slot) < MAX_NONZERO;
  assign row_we = cmd_i.load_write && row_ok
                  && (in_data_i.action == cseg_pkg::ACT_LOAD_ROW_END);
  assign col_we = cmd_i.load_write && nz_ok
                  && (in_data_i.action == cseg_pkg::ACT_LOAD_COLUMN);
  assign val_we = cmd_i.load_write && nz_ok
                  && (in_data_i.action == cseg_pkg::ACT_LOAD_VALUE);

  // read end of previous row first, then end of this row
  assign row_raddr = cmd_i.ptr_sel_end ? RW'(quot_q)
                                       : RW'(quot_q - cseg_pkg::DENSE_W'(1));

  cseg_ram #(.WIDTH(cseg_pkg::PTR_W), .DEPTH(MAX_ROWS)) u_row_end_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (RW'(in_data_i.slot)),
    .wdata_i (in_data_i.load_word[cseg_pkg::PTR_W-1:0]),
    .raddr_i (row_raddr),
    .rdata_o (row_rdata)
  );

  cseg_ram #(.WIDTH(cseg_pkg::COL_W), .DEPTH(MAX_NONZERO)) u_column_ram (
    .clk_i   (clk_i),
    .we_i    (col_we),
    .waddr_i (NW'(in_data_i.slot)),
    .wdata_i (in_data_i.load_word[cseg_pkg::COL_W-1:0]),
    .raddr_i (NW'(pos_q)),
    .rdata_o (col_rdata)
  );

  cseg_ram #(.WIDTH(cseg_pkg::WORD_W), .DEPTH(MAX_NONZERO)) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (NW'(in_data_i.slot)),
    .wdata_i (in_data_i.load_word),
    .raddr_i (NW'(pos_q)),
    .rdata_o (val_rdata)
  );

  // restoring divider, one quotient bit per cycle
  logic [cseg_pkg::COL_W-1:0]   divisor;
  logic [cseg_pkg::DENSE_W-1:0] trial;
  logic                         fits;

  assign divisor = (cols_q == '0) ? cseg_pkg::COL_W'(1) : cols_q;
  assign trial   = {rem_q, quot_q[cseg_pkg::DENSE_W-1]};
  assign fits    = trial >= {1'b0, divisor};

  always_comb begin
    rem_d  = fits ? cseg_pkg::COL_W'(trial - {1'b0, divisor})
                  : trial[cseg_pkg::COL_W-1:0];
    quot_d = {quot_q[cseg_pkg::DENSE_W-2:0], fits};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fetch_start) begin
      quot_q    <= cseg_pkg::DENSE_W'(in_data_i.element)
                   + cseg_pkg::DENSE_W'(skip_q);
      rem_q     <= '0;
      div_cnt_q <= '0;
      hit_q     <= 1'b0;
      last_q    <= in_data_i.last_in;
    end else if (cmd_i.div_step) begin
      quot_q    <= quot_d;
      rem_q     <= rem_d;
      div_cnt_q <= div_cnt_q + cseg_pkg::DIV_CNT_W'(1);
    end
    if (cmd_i.cap_start) begin
      start_q <= (quot_q == '0) ? '0 : row_rdata;
    end
    if (cmd_i.cap_end) begin
      end_q <= row_rdata;
      pos_q <= start_q;
    end else if (cmd_i.pos_inc) begin
      pos_q <= pos_q + cseg_pkg::PTR_W'(1);
    end
    if (cmd_i.cap_hit) begin
      hit_q   <= 1'b1;
      value_q <= val_rdata;
    end
  end

  // output register
  logic out_valid_q;
  cseg_pkg::out_item_t out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.result_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.result_load) begin
      out_data_q.found        <= hit_q;
      out_data_q.out_of_range <= sts_o.row_oor;
      out_data_q.last_out     <= last_q;
      if (!hit_q) begin
        out_data_q.value <= '0;
      end else if (dp_q) begin
        out_data_q.value <= value_q;
      end else begin
        out_data_q.value <= {{cseg_pkg::HALF_W{1'b0}}, value_q[cseg_pkg::HALF_W-1:0]};
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign sts_o.div_last  = div_cnt_q == cseg_pkg::DIV_CNT_W'(cseg_pkg::DENSE_W - 1);
  assign sts_o.row_oor   = 32'(quot_q) >= MAX_ROWS;
  assign sts_o.scan_end  = (pos_q >= end_q) || (32'(pos_q) >= MAX_NONZERO);
  assign sts_o.col_match = col_rdata == rem_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

>>> rtl/csr_sparse_element_gather_top.sv
// ----------------------------------------------------------------------------
// csr_sparse_element_gather_top: CSR sparse matrix element lookup
// Holds a compressed-sparse-row matrix in three local RAMs (row end
// pointers, column indices, value words) filled by load requests, each of
// which gives no result. A fetch request adds the element skip to its
// element number, splits it into row and column with a one-bit-per-cycle
// divider, reads the row's two end pointers (unless the row is out of
// range) and scans the row's column indices through the single read port
// of the column and value RAMs, stopping at the first match. A result
// waits in an output register, so the next request is taken while it is
// still unread. Registers are to be written only while the block is idle;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
module csr_sparse_element_gather_top #(
  parameter int unsigned MAX_ROWS    = 64,
  parameter int unsigned MAX_NONZERO = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cseg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [cseg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  cseg_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output cseg_pkg::out_item_t             out_data_o
);

  cseg_pkg::cmd_t cmd;
  cseg_pkg::sts_t sts;

  cseg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_action_i (in_data_i.action),
    .in_ready_o  (in_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cseg_dp #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_NONZERO (MAX_NONZERO)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

`ifndef ASSERT_OFF
  a_found_excl_oor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.found && out_data_o.out_of_range))
    else $error("found and out_of_range both set");

  a_miss_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.found) |-> (out_data_o.value == '0))
    else $error("missed lookup returned nonzero value");

  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (in_data_i.action != cseg_pkg::ACT_FETCH)
     && !out_valid_o) |=> !out_valid_o)
    else $error("load request produced a result");

  a_fetch_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (in_data_i.action == cseg_pkg::ACT_FETCH))
    |=> !in_ready_o)
    else $error("accepted a request while a fetch is in progress");
`endif

endmodule
